// ===== sv/hcfp_pkg.sv =====
// ----------------------------------------------------------------------------
// hcfp_pkg
// Shared constants, types and helpers for the hex command frame parser.
// ----------------------------------------------------------------------------
package hcfp_pkg;

	localparam int BUFFER_DEPTH = 32;
	localparam int FRAME_LEN    = 20;
	localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
	localparam int FILL_W       = $clog2(BUFFER_DEPTH + 1);
	localparam int POS_W        = $clog2(FRAME_LEN);
	localparam int IN_DATA_W    = 16;
	localparam int OUT_DATA_W   = 72;
	localparam int ACC_W        = 64;

	// frame characters
	localparam logic [7:0] CH_START = 8'h3E; // '>'
	localparam logic [7:0] CH_BAR   = 8'h7C; // '|'
	localparam logic [7:0] CH_COLON = 8'h3A; // ':'
	localparam logic [7:0] CH_AT    = 8'h40; // '@'
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;

	// separator positions within the frame
	localparam logic [POS_W-1:0] POS_START = POS_W'(0);
	localparam logic [POS_W-1:0] POS_BAR   = POS_W'(3);
	localparam logic [POS_W-1:0] POS_COLON = POS_W'(6);
	localparam logic [POS_W-1:0] POS_AT    = POS_W'(15);
	localparam logic [POS_W-1:0] POS_LAST  = POS_W'(FRAME_LEN - 1);

	// mode codes
	localparam logic [7:0] MODE_RESET  = 8'h00;
	localparam logic [7:0] MODE_SEND   = 8'h01;
	localparam logic [7:0] MODE_START  = 8'h02;
	localparam logic [7:0] MODE_STOP   = 8'h03;
	localparam logic [7:0] MODE_RACE   = 8'h10;
	localparam logic [7:0] MODE_SIM    = 8'h31;

	// action codes
	localparam logic [2:0] ACT_RESET   = 3'd0;
	localparam logic [2:0] ACT_SEND    = 3'd1;
	localparam logic [2:0] ACT_START   = 3'd2;
	localparam logic [2:0] ACT_STOP    = 3'd3;
	localparam logic [2:0] ACT_RACE    = 3'd4;
	localparam logic [2:0] ACT_SIM     = 3'd5;
	localparam logic [2:0] ACT_REFUSED = 3'd6;
	localparam logic [2:0] ACT_UNKNOWN = 3'd7;

	localparam logic [7:0] TIMEOUT_RESET = 8'd50;

	// controller -> datapath
	typedef struct packed {
		logic             start;    // new decode: clear error, latch allow
		logic             allow;
		logic             chk_en;   // read data valid this cycle
		logic [POS_W-1:0] chk_pos;  // frame position of read data
		logic             load_out; // move decoded frame to output register
	} ctl_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic err;      // frame malformed
		logic out_free; // output register can take a word
	} dp_status_t;

	// {bad, value}: bad set for a non-hex character
	function automatic logic [4:0] hex_nibble(input logic [7:0] ch);
		logic [4:0] r;
		r = 5'h10;
		if (ch >= 8'h30 && ch <= 8'h39)
			r = {1'b0, 4'(ch - 8'h30)};
		else if (ch >= 8'h41 && ch <= 8'h46)
			r = {1'b0, 4'(ch - 8'h37)};
		else if (ch >= 8'h61 && ch <= 8'h66)
			r = {1'b0, 4'(ch - 8'h57)};
		return r;
	endfunction

	function automatic logic [2:0] action_of(input logic [7:0] mode, input logic allow);
		logic [2:0] a;
		case (mode)
			MODE_RESET: a = ACT_RESET;
			MODE_SEND:  a = ACT_SEND;
			MODE_START: a = ACT_START;
			MODE_STOP:  a = ACT_STOP;
			MODE_RACE:  a = allow ? ACT_RACE : ACT_REFUSED;
			MODE_SIM:   a = allow ? ACT_SIM : ACT_REFUSED;
			default:    a = ACT_UNKNOWN;
		endcase
		return a;
	endfunction

endpackage

// ===== sv/hcfp_ram.sv =====
// ----------------------------------------------------------------------------
// hcfp_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module hcfp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

// ===== sv/hcfp_ctrl.sv =====
// ----------------------------------------------------------------------------
// hcfp_ctrl
// Controller: input handshake, fill and idle counters, decode sequencing.
// ----------------------------------------------------------------------------
module hcfp_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [7:0]                     cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [hcfp_pkg::IN_DATA_W-1:0] s_tdata,
	input  logic                           s_tuser,
	input  hcfp_pkg::dp_status_t           dp_status,
	output hcfp_pkg::ctl_cmd_t             ctl_cmd,
	output logic                           wr_en,
	output logic [hcfp_pkg::ADDR_W-1:0]    wr_addr,
	output logic                           rd_en,
	output logic [hcfp_pkg::ADDR_W-1:0]    rd_addr
);
	import hcfp_pkg::*;

	typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DRAIN, ST_EMIT} state_t;

	state_t            state_q;
	logic [FILL_W-1:0] fill_q;
	logic [7:0]        idle_q;
	logic [7:0]        timeout_q;
	logic [POS_W-1:0]  rd_idx_q;
	logic              chk_en_s1;
	logic [POS_W-1:0]  chk_pos_s1;

	logic              accept, is_byte, crlf, go, long_enough;
	logic [FILL_W-1:0] fill_inc, len;
	logic [7:0]        idle_nx;
	logic [7:0]        ch;

	assign ch       = s_tdata[7:0];
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign is_byte  = !s_tuser;
	assign crlf     = (ch == CH_CR) || (ch == CH_LF);
	assign fill_inc = fill_q + FILL_W'(1);
	assign idle_nx  = (idle_q == 8'hFF) ? idle_q : idle_q + 8'd1;

	always_comb begin
		if (is_byte) begin
			len = crlf ? fill_q : fill_inc;
			go  = crlf || (fill_inc == FILL_W'(BUFFER_DEPTH));
		end else begin
			len = fill_q;
			go  = (fill_q != '0) && (idle_nx >= timeout_q);
		end
	end
	assign long_enough = (len >= FILL_W'(FRAME_LEN));

	assign wr_en   = accept && is_byte && !crlf;
	assign wr_addr = fill_q[ADDR_W-1:0];
	assign rd_en   = (state_q == ST_WALK);
	assign rd_addr = ADDR_W'(rd_idx_q);

	always_comb begin
		ctl_cmd.start    = accept && go && long_enough;
		ctl_cmd.allow    = s_tdata[8];
		ctl_cmd.chk_en   = chk_en_s1;
		ctl_cmd.chk_pos  = chk_pos_s1;
		ctl_cmd.load_out = (state_q == ST_EMIT) && !dp_status.err && dp_status.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fill_q     <= '0;
			idle_q     <= '0;
			timeout_q  <= TIMEOUT_RESET;
			rd_idx_q   <= '0;
			chk_en_s1  <= 1'b0;
			chk_pos_s1 <= '0;
		end else begin
			if (cfg_we)
				timeout_q <= cfg_wdata;
			chk_en_s1  <= rd_en;
			chk_pos_s1 <= rd_idx_q;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						idle_q <= is_byte ? 8'd0 : idle_nx;
						if (go)
							fill_q <= '0;
						else if (is_byte && !crlf)
							fill_q <= fill_inc;
						if (go && long_enough) begin
							rd_idx_q <= '0;
							state_q  <= ST_WALK;
						end
					end
				end
				ST_WALK: begin
					rd_idx_q <= rd_idx_q + POS_W'(1);
					if (rd_idx_q == POS_LAST)
						state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (dp_status.err || dp_status.out_free)
						state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== sv/hcfp_datapath.sv =====
// ----------------------------------------------------------------------------
// hcfp_datapath
// Datapath: checks separators, gathers hex digits, holds the result word.
// ----------------------------------------------------------------------------
module hcfp_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  hcfp_pkg::ctl_cmd_t              ctl_cmd,
	input  logic [7:0]                      rd_data,
	output hcfp_pkg::dp_status_t            dp_status,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [hcfp_pkg::OUT_DATA_W-1:0] m_tdata
);
	import hcfp_pkg::*;

	logic [ACC_W-1:0] acc_q;
	logic             err_q;
	logic             allow_q;
	logic             out_valid_q;
	logic [2:0]       action_q;
	logic [7:0]       mode_q, laps_q;
	logic [31:0]      tms_q;
	logic [15:0]      dbg_q;

	logic [4:0] nib;
	logic       is_sep, sep_ok;

	assign nib = hex_nibble(rd_data);

	always_comb begin
		is_sep = 1'b1;
		sep_ok = 1'b0;
		case (ctl_cmd.chk_pos)
			POS_START: sep_ok = (rd_data == CH_START);
			POS_BAR:   sep_ok = (rd_data == CH_BAR);
			POS_COLON: sep_ok = (rd_data == CH_COLON);
			POS_AT:    sep_ok = (rd_data == CH_AT);
			default:   is_sep = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q       <= 1'b0;
			allow_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ctl_cmd.start) begin
				err_q   <= 1'b0;
				allow_q <= ctl_cmd.allow;
			end else if (ctl_cmd.chk_en) begin
				if (is_sep ? !sep_ok : nib[4])
					err_q <= 1'b1;
			end
			if (ctl_cmd.load_out)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// digit shift register and result payload
	always_ff @(posedge clk) begin
		if (ctl_cmd.chk_en && !is_sep)
			acc_q <= {acc_q[ACC_W-5:0], nib[3:0]};
		if (ctl_cmd.load_out) begin
			mode_q   <= acc_q[63:56];
			laps_q   <= acc_q[55:48];
			tms_q    <= acc_q[47:16];
			dbg_q    <= acc_q[15:0];
			action_q <= action_of(acc_q[63:56], allow_q);
		end
	end

	assign dp_status.err      = err_q;
	assign dp_status.out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, dbg_q, tms_q, laps_q, mode_q, action_q};

endmodule

// ===== sv/hex_command_frame_parser_core.sv =====
// ----------------------------------------------------------------------------
// hex_command_frame_parser_core
// Decode path: a word that completes a 20+ character frame gives its result word
//   after the buffer walk, the registered buffer read, the drain state and the emit state.
// Throughput: words that trigger no decode are taken one per cycle; a decoding
//   word holds the input off through the buffer walk, drain and emit,
//   and longer while an earlier result word still waits.
// Reset: arst_n clears counters, state, output valid; timeout returns to 50.
// ----------------------------------------------------------------------------
// Buffers received characters and decodes ">MM|LL:TTTTTTTT@PPPP" frames.
// A decode fires on CR/LF, on the buffer filling, or on the idle timeout.
// Short buffers are simply dropped; only frames of 20+ characters are walked.
// ----------------------------------------------------------------------------
module hex_command_frame_parser_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration: timeout_ticks
	input  logic                            cfg_we,
	input  logic [7:0]                      cfg_wdata,
	// input words
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [hcfp_pkg::IN_DATA_W-1:0]  s_tdata,  // [7:0] byte_value, [8] allow_new
	input  logic                            s_tuser,  // [0] command (1 = ms tick)
	// result words
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [hcfp_pkg::OUT_DATA_W-1:0] m_tdata   // [2:0] action, [10:3] mode_code,
	                                                  // [18:11] max_laps, [50:19] max_time_ms,
	                                                  // [66:51] debug_flag_word
);
	import hcfp_pkg::*;

	ctl_cmd_t          ctl_cmd;
	dp_status_t        dp_status;
	logic              wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [7:0]        rd_data;

	// sequencing, counters and timeout register
	hcfp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.dp_status (dp_status),
		.ctl_cmd   (ctl_cmd),
		.wr_en     (wr_en),
		.wr_addr   (wr_addr),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr)
	);

	// character buffer; contents undefined until written, reads stay below fill
	hcfp_ram #(
		.WIDTH (8),
		.DEPTH (BUFFER_DEPTH)
	) u_buf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (s_tdata[7:0]),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// frame checking, digit gathering, result register
	hcfp_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_cmd   (ctl_cmd),
		.rd_data   (rd_data),
		.dp_status (dp_status),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	// no new word while the buffer is being walked
	a_no_accept_in_walk: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !s_tready)
		else $error("input taken during buffer walk");

	// a result never overwrites one still waiting
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_cmd.load_out |-> (!m_tvalid || m_tready))
		else $error("result register overwritten");

	// a taken result leaves unless replaced
	a_out_drops: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !ctl_cmd.load_out) |=> !m_tvalid)
		else $error("result word repeated");

	// buffer read and write never overlap
	a_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		!(rd_en && wr_en))
		else $error("buffer read and write together");

endmodule
